### rtl/assert_macros.svh
// Assertion helpers shared by the grant queue modules.
// GQ_ASSERT is checked out of reset; GQ_ASSERT_NR is checked during reset too.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define GQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define GQ_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/gq_pkg.sv
`default_nettype none

package gq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_REQUEST = 2'd0,
        OP_RELEASE = 2'd1,
        OP_CONFIRM = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NOT_QUEUED = 2'd2
    } status_t;

    typedef enum logic {
        CTL_EMPTY = 1'b0,
        CTL_HOLD  = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic exec;
    } ctl_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/gq_if.sv
`default_nettype none

interface gq_req_if;
    import gq_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [ID_BITS-1:0] requester_id;

    modport source (output valid, output op, output requester_id, input ready);
    modport sink   (input valid, input op, input requester_id, output ready);
endinterface

interface gq_res_if;
    import gq_pkg::*;

    logic               valid;
    logic               ready;
    logic               grant;
    logic [ID_BITS-1:0] granted_id;
    logic [1:0]         status;
    logic [CNT_W-1:0]   queue_count;

    modport source (output valid, output grant, output granted_id, output status,
                    output queue_count, input ready);
    modport sink   (input valid, input grant, input granted_id, input status,
                    input queue_count, output ready);
endinterface

`default_nettype wire

### rtl/fifo_mutex_grant_queue.sv
// Latency: a request's result is registered and offered the cycle after it is accepted.
// Throughput: one request per cycle while results are taken; queue match, removal and
// compaction happen in the accept cycle; a waiting result is taken as the next request enters.
// Reset: rst_n asynchronous, active low; empties the queue and the result register.
// Queue entries are not cleared; the fill count marks which are live.
`default_nettype none

module fifo_mutex_grant_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    gq_req_if.sink    req,
    gq_res_if.source  res
);
    import gq_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    gq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    gq_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (req.op),
        .requester_id (req.requester_id),
        .grant        (res.grant),
        .granted_id   (res.granted_id),
        .status       (res.status),
        .queue_count  (res.queue_count)
    );

endmodule

`default_nettype wire

### rtl/gq_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module gq_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output gq_pkg::ctl_cmd_t      cmd,
    input  wire gq_pkg::dp_stat_t stat
);
    import gq_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_EMPTY;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result register frees up in the same cycle it is taken
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            CTL_EMPTY:
            begin
                in_ready = 1'b1;
                cmd.exec = in_valid;
                if (in_valid)
                begin
                    state_next = CTL_HOLD;
                end
            end
            CTL_HOLD:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                cmd.exec  = in_valid && out_ready;
                if (out_ready && !in_valid)
                begin
                    state_next = CTL_EMPTY;
                end
            end
            default:
            begin
                state_next = CTL_EMPTY;
            end
        endcase
    end

    `GQ_ASSERT(a_no_overwrite, (out_valid && !out_ready) |-> !cmd.exec, "result overwritten")
    `GQ_ASSERT(a_exec_shows, cmd.exec |=> out_valid, "executed request gives no result")
    `GQ_ASSERT(a_stat_sane, !(stat.empty && stat.full), "queue both empty and full")
    `GQ_ASSERT_NR(a_rst_idle, !rst_n |-> !out_valid, "result valid in reset")

endmodule

`default_nettype wire

### rtl/gq_dpath.sv
`default_nettype none
`include "assert_macros.svh"

module gq_dpath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire gq_pkg::ctl_cmd_t            cmd,
    output gq_pkg::dp_stat_t                 stat,
    input  wire logic [1:0]                  op,
    input  wire logic [gq_pkg::ID_BITS-1:0]  requester_id,
    output logic                             grant,
    output logic [gq_pkg::ID_BITS-1:0]       granted_id,
    output logic [1:0]                       status,
    output logic [gq_pkg::CNT_W-1:0]         queue_count
);
    import gq_pkg::*;

    // queue entries, index 0 is the lock holder
    logic [ID_BITS-1:0] q_reg  [QUEUE_DEPTH];
    logic [ID_BITS-1:0] q_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic               res_grant_reg;
    logic [ID_BITS-1:0] res_id_reg;
    status_t            res_status_reg;
    logic [CNT_W-1:0]   res_count_reg;

    logic               res_grant_next;
    logic [ID_BITS-1:0] res_id_next;
    status_t            res_status_next;

    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] shift;

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            match[i] = (CNT_W'(i) < count_reg) && (q_reg[i] == requester_id);
        end
        // entries at or behind the first match move up one place on removal
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            shift[i] = 1'b0;
            for (int j = 0; j <= i; j++)
            begin
                shift[i] = shift[i] | match[j];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        count_next      = count_reg;
        res_grant_next  = 1'b0;
        res_id_next     = '0;
        res_status_next = STAT_OK;
        case (op)
            OP_REQUEST:
            begin
                if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    res_status_next = STAT_FULL;
                end
                else
                begin
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (CNT_W'(i) == count_reg)
                        begin
                            q_next[i] = requester_id;
                        end
                    end
                    count_next = count_reg + CNT_W'(1);
                    if (count_reg == '0)
                    begin
                        res_grant_next = 1'b1;
                        res_id_next    = requester_id;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (|match)
                begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        if (shift[i])
                        begin
                            q_next[i] = q_reg[i+1];
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                    if (match[0] && (count_reg > CNT_W'(1)))
                    begin
                        res_grant_next = 1'b1;
                        res_id_next    = q_reg[1];
                    end
                end
                else
                begin
                    res_status_next = STAT_NOT_QUEUED;
                end
            end
            OP_CONFIRM:
            begin
                if (match[0])
                begin
                    res_grant_next = 1'b1;
                    res_id_next    = requester_id;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                q_reg[i] <= q_next[i];
            end
            res_grant_reg  <= res_grant_next;
            res_id_reg     <= res_id_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= count_next;
        end
    end

    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign grant       = res_grant_reg;
    assign granted_id  = res_id_reg;
    assign status      = res_status_reg;
    assign queue_count = res_count_reg;

    `GQ_ASSERT(a_count_range, count_reg <= CNT_W'(QUEUE_DEPTH), "count beyond depth")
    `GQ_ASSERT(a_full_refused, (cmd.exec && stat.full && op == OP_REQUEST) |=> (count_reg == $past(count_reg)), "full queue took a request")
    `GQ_ASSERT(a_count_shown, cmd.exec |=> (res_count_reg == count_reg), "reported count differs from queue")

endmodule

`default_nettype wire

### verif/fifo_mutex_grant_queue_tb.sv
`timescale 1ns / 100ps

import gq_pkg::*;

// op code three carries no operation; the block must ignore it
localparam logic [1:0] OP_UNUSED = 2'd3;

typedef struct packed {
    logic               grant;
    logic [ID_BITS-1:0] granted_id;
    status_t            status;
    logic [CNT_W-1:0]   queue_count;
} grant_result_t;

class lock_queue_scoreboard;
    logic [ID_BITS-1:0] lock_queue[$];
    grant_result_t      expected_grants[$];
    int                 mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Mirror the lock queue for one accepted request and store the expected result.
    function void note_request(logic [1:0] op, logic [ID_BITS-1:0] id);
        grant_result_t r;
        int            pos;
        r = '0;
        r.status = STAT_OK;
        pos = -1;
        case (op)
            OP_REQUEST:
            begin
                if (lock_queue.size() >= QUEUE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    lock_queue.insert(lock_queue.size(), id);
                    if (lock_queue.size() == 1)
                    begin
                        r.grant = 1'b1;
                        r.granted_id = id;
                    end
                end
            end
            OP_RELEASE:
            begin
                if (lock_queue.size() == 0)
                    r.status = STAT_NOT_QUEUED;
                else if (lock_queue[0] == id)
                begin
                    lock_queue.delete(0);
                    if (lock_queue.size() > 0)
                    begin
                        r.grant = 1'b1;
                        r.granted_id = lock_queue[0];
                    end
                end
                else
                begin
                    // cancel the first waiting match behind the holder
                    for (int i = 1; i < lock_queue.size(); i++)
                        if (pos < 0 && lock_queue[i] == id)
                            pos = i;
                    if (pos < 0)
                        r.status = STAT_NOT_QUEUED;
                    else
                        lock_queue.delete(pos);
                end
            end
            OP_CONFIRM:
            begin
                if (lock_queue.size() > 0 && lock_queue[0] == id)
                begin
                    r.grant = 1'b1;
                    r.granted_id = id;
                end
            end
            default:
                ;
        endcase
        r.queue_count = CNT_W'(lock_queue.size());
        expected_grants.insert(expected_grants.size(), r);
    endfunction

    function void check_result(grant_result_t got);
        grant_result_t exp;
        if (expected_grants.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result grant=%b id=%h status=%0d count=%0d",
                         $time, got.grant, got.granted_id, got.status, got.queue_count);
            return;
        end
        exp = expected_grants[0];
        expected_grants.delete(0);
        if (got.grant !== exp.grant || got.granted_id !== exp.granted_id ||
            got.status !== exp.status || got.queue_count !== exp.queue_count)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch exp grant=%b id=%h status=%0d count=%0d, ",
                         $time, exp.grant, exp.granted_id, exp.status, exp.queue_count,
                         "got grant=%b id=%h status=%0d count=%0d",
                         got.grant, got.granted_id, got.status, got.queue_count);
        end
    endfunction
endclass

module fifo_mutex_grant_queue_tb;

    localparam int STALL_LIMIT = 1000;

    logic clk;
    logic rst_n;

    gq_req_if req_ch();
    gq_res_if res_ch();

    fifo_mutex_grant_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    lock_queue_scoreboard sb = new();

    int sender_gap_pct;
    int receiver_stall_pct;
    int quiet_cycles;

    logic [ID_BITS-1:0] id_pool [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5,
                                       8'h01, 8'h80, 8'h3C, 8'h7E};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        grant_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.grant       = res_ch.grant;
            got.granted_id  = res_ch.granted_id;
            got.status      = status_t'(res_ch.status);
            got.queue_count = res_ch.queue_count;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [ID_BITS-1:0] id);
        @(negedge clk);
        while (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.requester_id <= id;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, id);
    endtask

    // Mostly well-formed traffic: releases and confirms aim at queued ids.
    task automatic pick_request(input int request_pct, output logic [1:0] op,
                                output logic [ID_BITS-1:0] id);
        int r;
        int n;
        r  = $urandom_range(99);
        n  = sb.lock_queue.size();
        id = ($urandom_range(9) < 7) ? id_pool[$urandom_range(7)] : ID_BITS'($urandom);
        if (r < request_pct)
            op = OP_REQUEST;
        else if (r < request_pct + (100 - request_pct) * 3 / 4)
        begin
            op = OP_RELEASE;
            r  = $urandom_range(9);
            if (n > 0 && r < 4)
                id = sb.lock_queue[0];
            else if (n > 0 && r < 8)
                id = sb.lock_queue[$urandom_range(n - 1)];
        end
        else
        begin
            op = OP_CONFIRM;
            if (n > 0 && $urandom_range(9) < 6)
                id = sb.lock_queue[0];
        end
    endtask

    initial
    begin
        logic [1:0]         op;
        logic [ID_BITS-1:0] id;
        int                 bias;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_REQUEST;
        req_ch.requester_id = '0;
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        quiet_cycles       = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty queue cases, then fill to the brim and beyond
        send_request(OP_RELEASE, 8'h00);
        send_request(OP_CONFIRM, 8'hFF);
        send_request(OP_UNUSED, 8'hAA);
        send_request(OP_REQUEST, 8'h00);
        send_request(OP_REQUEST, 8'hFF);
        send_request(OP_REQUEST, 8'hFF);
        for (int i = 3; i < QUEUE_DEPTH; i++)
            send_request(OP_REQUEST, ID_BITS'(i * 8'h13));
        send_request(OP_REQUEST, 8'h42);
        send_request(OP_CONFIRM, 8'h00);
        send_request(OP_CONFIRM, 8'hFF);
        send_request(OP_RELEASE, 8'hFF);
        send_request(OP_RELEASE, 8'h42);
        send_request(OP_RELEASE, 8'h00);

        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_gap_pct = 66; receiver_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  receiver_stall_pct = 66; end
                default: begin sender_gap_pct = 8; receiver_stall_pct = 8; end
            endcase
            for (int k = 0; k < 75; k++)
            begin
                // shift the request mix now and then so the queue swings full and empty
                if (k % 25 == 0)
                    case ($urandom_range(2))
                        0: bias = 30;
                        1: bias = 50;
                        default: bias = 75;
                    endcase
                pick_request(bias, op, id);
                send_request(op, id);
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        receiver_stall_pct = 0;
        while (sb.expected_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
